/* sv/sensor_frame_target_transform_top_macros.svh */
// assertion macros shared by the sensor frame transform rtl
// expects aclk and aresetn in the scope of each use
`ifndef SENSOR_FRAME_TARGET_TRANSFORM_TOP_MACROS_SVH
`define SENSOR_FRAME_TARGET_TRANSFORM_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SFFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sfft_pkg.sv */
// shared types and constants of the sensor frame target transform
// no dependencies
package sfft_pkg;

    localparam int SIN_STAGES  = 5;
    localparam int CORE_STAGES = 4;

    // quarter-wave sine polynomial coefficients, q30
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [26:0] SIN_C = 27'd76016977;

    // floor(n / 50) = (n * COG_RECIP) >> COG_SHIFT for n below 2^21
    localparam logic [21:0] COG_RECIP = 22'd2684355;
    localparam int          COG_SHIFT = 27;

    localparam logic [1:0] CFG_MOUNT_X   = 2'd0;
    localparam logic [1:0] CFG_MOUNT_Y   = 2'd1;
    localparam logic [1:0] CFG_MOUNT_YAW = 2'd2;

    typedef enum logic [1:0] {
        FRAME_REAR   = 2'd0,
        FRAME_COG    = 2'd1,
        FRAME_SENSOR = 2'd2
    } frame_code_t;

    typedef enum logic [2:0] {
        BEAT_REAR   = 3'b001,
        BEAT_COG    = 3'b010,
        BEAT_SENSOR = 3'b100
    } beat_t;

    typedef struct packed {
        logic in_sensor;
        logic at_bumper;
    } item_ctrl_t;

endpackage

/* sv/sfft_sin.sv */
// five-stage pipelined fixed-point sine, q30 result from a 32-bit phase
// depends on sfft_pkg
module sfft_sin (
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] sin_q30
);
    import sfft_pkg::*;

    logic [16:0] z0_reg, z1_reg, z2s_reg, z3_reg;
    logic [3:0]  neg_reg;
    logic [32:0] zz1_reg, zz2_reg;
    logic [29:0] t1_reg;
    logic [30:0] t3_reg;
    logic signed [31:0] out_reg;

    logic [16:0] z_next;
    logic [59:0] pc;
    logic [62:0] pb;
    logic [47:0] pa;
    logic [29:0] t1_next;
    logic [30:0] t3_next;
    logic [31:0] mag;

    always_comb begin
        // odd quadrants run the quarter wave backwards
        z_next  = phase[30] ? (17'h10000 - {1'b0, phase[29:14]}) : {1'b0, phase[29:14]};
        pc      = 60'(SIN_C) * 60'(zz1_reg);
        t1_next = SIN_B - 30'(pc[59:32]);
        pb      = 63'(t1_reg) * 63'(zz2_reg);
        t3_next = SIN_A - pb[62:32];
        pa      = 48'(t3_reg) * 48'(z3_reg);
        mag     = pa[47:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg  <= z_next;
            neg_reg <= {neg_reg[2:0], phase[31]};
            zz1_reg <= 33'(z0_reg) * 33'(z0_reg);
            z1_reg  <= z0_reg;
            t1_reg  <= t1_next;
            zz2_reg <= zz1_reg;
            z2s_reg <= z1_reg;
            t3_reg  <= t3_next;
            z3_reg  <= z2s_reg;
            out_reg <= neg_reg[3] ? -$signed(mag) : $signed(mag);
        end
    end

    assign sin_q30 = out_reg;

endmodule

/* sv/sfft_core.sv */
// four-stage rotate, translate, centre-of-gravity and half-length shift datapath
// depends on sfft_pkg
module sfft_core #(
    parameter int PW = 24,
    parameter int AW = 16
) (
    input  logic                   aclk,
    input  logic                   en,
    input  sfft_pkg::item_ctrl_t   ctrl_in,
    input  logic [15:0]            len_in,
    input  logic signed [PW-1:0]   px_in,
    input  logic signed [PW-1:0]   py_in,
    input  logic signed [PW-1:0]   vx_in,
    input  logic signed [PW-1:0]   vy_in,
    input  logic [AW-1:0]          rh_in,
    input  logic [AW-1:0]          sh_in,
    input  logic signed [PW-1:0]   mx,
    input  logic signed [PW-1:0]   my,
    input  logic signed [31:0]     cy,
    input  logic signed [31:0]     sy,
    input  logic signed [31:0]     cr,
    input  logic signed [31:0]     sr,
    input  logic signed [31:0]     cs,
    input  logic signed [31:0]     ss,
    output logic signed [PW-1:0]   rx_out,
    output logic signed [PW-1:0]   ry_out,
    output logic signed [PW-1:0]   rvx_out,
    output logic signed [PW-1:0]   rvy_out,
    output logic signed [PW-1:0]   gx_out,
    output logic signed [PW-1:0]   gy_out,
    output logic signed [PW-1:0]   sx_out,
    output logic signed [PW-1:0]   sy_out,
    output logic signed [PW-1:0]   svx_out,
    output logic signed [PW-1:0]   svy_out,
    output logic [AW-1:0]          rh_out,
    output logic [AW-1:0]          sh_out
);
    import sfft_pkg::*;

    localparam int EW = PW + 4;
    localparam int MW = PW + 33;
    localparam int SW = PW + 34;
    localparam logic signed [EW-1:0] SMAX = {5'b00000, {(PW-1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = {5'b11111, {(PW-1){1'b0}}};

    function automatic logic signed [PW-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [PW-1:0] r;
        if (v > SMAX) r = {1'b0, {(PW-1){1'b1}}};
        else if (v < SMIN) r = {1'b1, {(PW-1){1'b0}}};
        else r = v[PW-1:0];
        return r;
    endfunction

    function automatic logic signed [EW-1:0] ext(input logic signed [PW-1:0] v);
        return {{4{v[PW-1]}}, v};
    endfunction

    function automatic logic signed [PW-1:0] rnd30(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] w;
        w = v + (SW'(1) <<< 29);
        return sat(w[SW-1:30]);
    endfunction

    function automatic logic signed [18:0] rnd31(input logic signed [48:0] v);
        logic signed [49:0] w;
        w = {v[48], v} + (50'sd1 <<< 30);
        return w[49:31];
    endfunction

    // ---------------- stage 1: products
    item_ctrl_t c1_reg;
    logic signed [MW-1:0] ac_reg, bs_reg, bc_reg, as_reg;
    logic signed [MW-1:0] uc_reg, ws_reg, wc_reg, us_reg;
    logic signed [48:0] lcr_reg, lsr_reg, lcs_reg, lss_reg;
    logic [15:0] q1_reg;
    logic signed [PW-1:0] px1_reg, py1_reg, vx1_reg, vy1_reg;
    logic [AW-1:0] rh1_reg, sh1_reg;

    logic signed [PW:0] a1, b1, u1, w1;
    logic signed [16:0] lens;
    logic [20:0] cog_n;
    logic [42:0] cog_p;

    always_comb begin
        a1    = ctrl_in.in_sensor ? {px_in[PW-1], px_in} : ({px_in[PW-1], px_in} - {mx[PW-1], mx});
        b1    = ctrl_in.in_sensor ? {py_in[PW-1], py_in} : ({py_in[PW-1], py_in} - {my[PW-1], my});
        u1    = {vx_in[PW-1], vx_in};
        w1    = {vy_in[PW-1], vy_in};
        lens  = {1'b0, len_in};
        cog_n = {1'b0, len_in, 4'b0000} + 21'd25;
        cog_p = 43'(cog_n) * 43'(COG_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg  <= ctrl_in;
            ac_reg  <= MW'(a1 * cy);
            bs_reg  <= MW'(b1 * sy);
            bc_reg  <= MW'(b1 * cy);
            as_reg  <= MW'(a1 * sy);
            uc_reg  <= MW'(u1 * cy);
            ws_reg  <= MW'(w1 * sy);
            wc_reg  <= MW'(w1 * cy);
            us_reg  <= MW'(u1 * sy);
            lcr_reg <= 49'(lens * cr);
            lsr_reg <= 49'(lens * sr);
            lcs_reg <= 49'(lens * cs);
            lss_reg <= 49'(lens * ss);
            q1_reg  <= cog_p[COG_SHIFT+15:COG_SHIFT];
            px1_reg <= px_in;
            py1_reg <= py_in;
            vx1_reg <= vx_in;
            vy1_reg <= vy_in;
            rh1_reg <= rh_in;
            sh1_reg <= sh_in;
        end
    end

    // ---------------- stage 2: sums, rounding, saturation
    item_ctrl_t c2_reg;
    logic signed [PW-1:0] xr2_reg, yr2_reg, vxr2_reg, vyr2_reg;
    logic signed [18:0] dcr_reg, dsr_reg, dcs_reg, dss_reg;
    logic [15:0] q2_reg;
    logic signed [PW-1:0] px2_reg, py2_reg, vx2_reg, vy2_reg;
    logic [AW-1:0] rh2_reg, sh2_reg;

    logic signed [SW-1:0] xs, ys, vxs, vys;

    always_comb begin
        if (c1_reg.in_sensor) begin
            xs  = SW'(ac_reg) - SW'(bs_reg);
            ys  = SW'(as_reg) + SW'(bc_reg);
            vxs = SW'(uc_reg) - SW'(ws_reg);
            vys = SW'(us_reg) + SW'(wc_reg);
        end else begin
            xs  = SW'(ac_reg) + SW'(bs_reg);
            ys  = SW'(bc_reg) - SW'(as_reg);
            vxs = SW'(uc_reg) + SW'(ws_reg);
            vys = SW'(wc_reg) - SW'(us_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg   <= c1_reg;
            xr2_reg  <= rnd30(xs);
            yr2_reg  <= rnd30(ys);
            vxr2_reg <= rnd30(vxs);
            vyr2_reg <= rnd30(vys);
            dcr_reg  <= rnd31(lcr_reg);
            dsr_reg  <= rnd31(lsr_reg);
            dcs_reg  <= rnd31(lcs_reg);
            dss_reg  <= rnd31(lss_reg);
            q2_reg   <= q1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
            rh2_reg  <= rh1_reg;
            sh2_reg  <= sh1_reg;
        end
    end

    // ---------------- stage 3: frame selection, mount offset, cog
    item_ctrl_t c3_reg;
    logic signed [PW-1:0] rx3_reg, ry3_reg, rvx3_reg, rvy3_reg, gx3_reg;
    logic signed [PW-1:0] sx3_reg, sy3_reg, svx3_reg, svy3_reg;
    logic signed [18:0] ecr_reg, esr_reg, ecs_reg, ess_reg;
    logic [AW-1:0] rh3_reg, sh3_reg;

    logic signed [PW-1:0] rx3, ry3;

    always_comb begin
        if (c2_reg.in_sensor) begin
            rx3 = sat(ext(xr2_reg) + ext(mx));
            ry3 = sat(ext(yr2_reg) + ext(my));
        end else begin
            rx3 = px2_reg;
            ry3 = py2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_reg   <= c2_reg;
            rx3_reg  <= rx3;
            ry3_reg  <= ry3;
            gx3_reg  <= sat(ext(rx3) + EW'(q2_reg));
            rvx3_reg <= c2_reg.in_sensor ? vxr2_reg : vx2_reg;
            rvy3_reg <= c2_reg.in_sensor ? vyr2_reg : vy2_reg;
            sx3_reg  <= c2_reg.in_sensor ? px2_reg : xr2_reg;
            sy3_reg  <= c2_reg.in_sensor ? py2_reg : yr2_reg;
            svx3_reg <= c2_reg.in_sensor ? vx2_reg : vxr2_reg;
            svy3_reg <= c2_reg.in_sensor ? vy2_reg : vyr2_reg;
            ecr_reg  <= dcr_reg;
            esr_reg  <= dsr_reg;
            ecs_reg  <= dcs_reg;
            ess_reg  <= dss_reg;
            rh3_reg  <= rh2_reg;
            sh3_reg  <= sh2_reg;
        end
    end

    // ---------------- stage 4: half-length shift along heading
    logic signed [PW-1:0] rx4_reg, ry4_reg, rvx4_reg, rvy4_reg, gx4_reg, gy4_reg;
    logic signed [PW-1:0] sx4_reg, sy4_reg, svx4_reg, svy4_reg;
    logic [AW-1:0] rh4_reg, sh4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (c3_reg.at_bumper) begin
                rx4_reg <= sat(ext(rx3_reg) + EW'(ecr_reg));
                ry4_reg <= sat(ext(ry3_reg) + EW'(esr_reg));
                sx4_reg <= sat(ext(sx3_reg) + EW'(ecs_reg));
                sy4_reg <= sat(ext(sy3_reg) + EW'(ess_reg));
            end else begin
                rx4_reg <= rx3_reg;
                ry4_reg <= ry3_reg;
                sx4_reg <= sx3_reg;
                sy4_reg <= sy3_reg;
            end
            // cog keeps the rear-axle y from before the shift
            gy4_reg  <= ry3_reg;
            gx4_reg  <= gx3_reg;
            rvx4_reg <= rvx3_reg;
            rvy4_reg <= rvy3_reg;
            svx4_reg <= svx3_reg;
            svy4_reg <= svy3_reg;
            rh4_reg  <= rh3_reg;
            sh4_reg  <= sh3_reg;
        end
    end

    assign rx_out  = rx4_reg;
    assign ry_out  = ry4_reg;
    assign rvx_out = rvx4_reg;
    assign rvy_out = rvy4_reg;
    assign gx_out  = gx4_reg;
    assign gy_out  = gy4_reg;
    assign sx_out  = sx4_reg;
    assign sy_out  = sy4_reg;
    assign svx_out = svx4_reg;
    assign svy_out = svy4_reg;
    assign rh_out  = rh4_reg;
    assign sh_out  = sh4_reg;

endmodule

/* sv/sensor_frame_target_transform_top.sv */
// pipeline: a taken target beat passes through five sine stages, then four datapath stages,
// then the result register.
// throughput: set by the three result beats per target on the single result channel;
// the pipeline itself takes a beat every cycle when it can drain.
// reset: aresetn synchronous active low, clears valid bits, beat state and mount registers.
`include "sensor_frame_target_transform_top_macros.svh"

// top level: input staging, sine units, datapath and three-beat result serialiser
// depends on sfft_pkg, sfft_sin, sfft_core
module sensor_frame_target_transform_top #(
    parameter int POS_WIDTH   = 24,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // target_length, heading, pos_x, pos_y, vel_x, vel_y
    input  logic [((16 + ANGLE_WIDTH + 4 * POS_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // input_frame, at_rear_bumper
    input  logic [1:0]           s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // out_x, out_y, out_vx, out_vy, out_heading
    output logic [((4 * POS_WIDTH + ANGLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    // frame_code
    output sfft_pkg::frame_code_t m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [POS_WIDTH-1:0] cfg_wdata
);
    import sfft_pkg::*;

    localparam int PW = POS_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int NSTG = SIN_STAGES + CORE_STAGES;
    localparam int OTW = ((4 * PW + AW + 7) / 8) * 8;
    localparam logic [AW-1:0] QUARTER = {2'b01, {(AW-2){1'b0}}};

    // mount registers
    logic signed [PW-1:0] mx_reg, my_reg;
    logic [AW-1:0] yaw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mx_reg  <= '0;
            my_reg  <= '0;
            yaw_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MOUNT_X:   mx_reg  <= cfg_wdata;
                CFG_MOUNT_Y:   my_reg  <= cfg_wdata;
                CFG_MOUNT_YAW: yaw_reg <= cfg_wdata[AW-1:0];
                default: ;
            endcase
        end
    end

    // input field unpacking
    logic [15:0] in_len;
    logic [AW-1:0] in_hd, in_rh, in_sh;
    logic signed [PW-1:0] in_px, in_py, in_vx, in_vy;
    item_ctrl_t in_ctrl;

    always_comb begin
        in_len = s_tdata[15:0];
        in_hd  = s_tdata[16 +: AW];
        in_px  = s_tdata[16 + AW +: PW];
        in_py  = s_tdata[16 + AW + PW +: PW];
        in_vx  = s_tdata[16 + AW + 2 * PW +: PW];
        in_vy  = s_tdata[16 + AW + 3 * PW +: PW];
        in_ctrl.in_sensor = s_tuser[0];
        in_ctrl.at_bumper = s_tuser[1];
        // the frame that matches the input passes the heading unchanged
        in_rh = in_ctrl.in_sensor ? (in_hd + yaw_reg) : in_hd;
        in_sh = in_ctrl.in_sensor ? in_hd : (in_hd - yaw_reg);
    end

    // pipeline control
    logic [NSTG-1:0] valid_reg;
    logic adv, ser_load, ser_valid_reg;
    beat_t beat_reg;

    assign ser_load = valid_reg[NSTG-1] &&
                      (!ser_valid_reg || (m_tready && beat_reg == BEAT_SENSOR));
    assign adv      = !valid_reg[NSTG-1] || ser_load;
    assign s_tready = adv && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NSTG-2:0], s_tvalid};
        end
    end

    // sine and cosine of mount yaw and of both output headings
    logic signed [31:0] cy, sy, cr, sr, cs, ss;

    sfft_sin u_sin_cy (.aclk(aclk), .en(adv),
        .phase({yaw_reg + QUARTER, {(32-AW){1'b0}}}), .sin_q30(cy));
    sfft_sin u_sin_sy (.aclk(aclk), .en(adv),
        .phase({yaw_reg, {(32-AW){1'b0}}}), .sin_q30(sy));
    sfft_sin u_sin_cr (.aclk(aclk), .en(adv),
        .phase({in_rh + QUARTER, {(32-AW){1'b0}}}), .sin_q30(cr));
    sfft_sin u_sin_sr (.aclk(aclk), .en(adv),
        .phase({in_rh, {(32-AW){1'b0}}}), .sin_q30(sr));
    sfft_sin u_sin_cs (.aclk(aclk), .en(adv),
        .phase({in_sh + QUARTER, {(32-AW){1'b0}}}), .sin_q30(cs));
    sfft_sin u_sin_ss (.aclk(aclk), .en(adv),
        .phase({in_sh, {(32-AW){1'b0}}}), .sin_q30(ss));

    // item fields ride alongside the sine stages
    logic [15:0] dl_len_reg [SIN_STAGES];
    logic signed [PW-1:0] dl_px_reg [SIN_STAGES];
    logic signed [PW-1:0] dl_py_reg [SIN_STAGES];
    logic signed [PW-1:0] dl_vx_reg [SIN_STAGES];
    logic signed [PW-1:0] dl_vy_reg [SIN_STAGES];
    logic [AW-1:0] dl_rh_reg [SIN_STAGES];
    logic [AW-1:0] dl_sh_reg [SIN_STAGES];
    item_ctrl_t dl_ctrl_reg [SIN_STAGES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_len_reg[0]  <= in_len;
            dl_px_reg[0]   <= in_px;
            dl_py_reg[0]   <= in_py;
            dl_vx_reg[0]   <= in_vx;
            dl_vy_reg[0]   <= in_vy;
            dl_rh_reg[0]   <= in_rh;
            dl_sh_reg[0]   <= in_sh;
            dl_ctrl_reg[0] <= in_ctrl;
            for (int i = 1; i < SIN_STAGES; i++) begin
                dl_len_reg[i]  <= dl_len_reg[i-1];
                dl_px_reg[i]   <= dl_px_reg[i-1];
                dl_py_reg[i]   <= dl_py_reg[i-1];
                dl_vx_reg[i]   <= dl_vx_reg[i-1];
                dl_vy_reg[i]   <= dl_vy_reg[i-1];
                dl_rh_reg[i]   <= dl_rh_reg[i-1];
                dl_sh_reg[i]   <= dl_sh_reg[i-1];
                dl_ctrl_reg[i] <= dl_ctrl_reg[i-1];
            end
        end
    end

    logic signed [PW-1:0] rx, ry, rvx, rvy, gx, gy, sx, sy_p, svx, svy;
    logic [AW-1:0] rh, sh;

    sfft_core #(.PW(PW), .AW(AW)) u_core (
        .aclk(aclk), .en(adv),
        .ctrl_in(dl_ctrl_reg[SIN_STAGES-1]),
        .len_in(dl_len_reg[SIN_STAGES-1]),
        .px_in(dl_px_reg[SIN_STAGES-1]), .py_in(dl_py_reg[SIN_STAGES-1]),
        .vx_in(dl_vx_reg[SIN_STAGES-1]), .vy_in(dl_vy_reg[SIN_STAGES-1]),
        .rh_in(dl_rh_reg[SIN_STAGES-1]), .sh_in(dl_sh_reg[SIN_STAGES-1]),
        .mx(mx_reg), .my(my_reg),
        .cy(cy), .sy(sy), .cr(cr), .sr(sr), .cs(cs), .ss(ss),
        .rx_out(rx), .ry_out(ry), .rvx_out(rvx), .rvy_out(rvy), .gx_out(gx),
        .gy_out(gy),
        .sx_out(sx), .sy_out(sy_p), .svx_out(svx), .svy_out(svy),
        .rh_out(rh), .sh_out(sh)
    );

    // result serialiser: rear, cog, sensor beats
    logic signed [PW-1:0] o_rx_reg, o_ry_reg, o_rvx_reg, o_rvy_reg, o_gx_reg, o_gy_reg;
    logic signed [PW-1:0] o_sx_reg, o_sy_reg, o_svx_reg, o_svy_reg;
    logic [AW-1:0] o_rh_reg, o_sh_reg;
    beat_t beat_next;

    always_ff @(posedge aclk) begin
        if (ser_load) begin
            o_rx_reg  <= rx;
            o_ry_reg  <= ry;
            o_rvx_reg <= rvx;
            o_rvy_reg <= rvy;
            o_gx_reg  <= gx;
            o_gy_reg  <= gy;
            o_sx_reg  <= sx;
            o_sy_reg  <= sy_p;
            o_svx_reg <= svx;
            o_svy_reg <= svy;
            o_rh_reg  <= rh;
            o_sh_reg  <= sh;
        end
    end

    always_comb begin
        beat_next = beat_reg;
        if (ser_load) begin
            beat_next = BEAT_REAR;
        end else if (ser_valid_reg && m_tready) begin
            unique case (beat_reg)
                BEAT_REAR:   beat_next = BEAT_COG;
                BEAT_COG:    beat_next = BEAT_SENSOR;
                BEAT_SENSOR: beat_next = BEAT_REAR;
                default:     beat_next = BEAT_REAR;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            beat_reg      <= BEAT_REAR;
        end else begin
            beat_reg <= beat_next;
            if (ser_load) begin
                ser_valid_reg <= 1'b1;
            end else if (m_tready && beat_reg == BEAT_SENSOR) begin
                ser_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        unique case (beat_reg)
            BEAT_REAR: begin
                m_tdata = OTW'({o_rh_reg, o_rvy_reg, o_rvx_reg, o_ry_reg, o_rx_reg});
                m_tuser = FRAME_REAR;
            end
            BEAT_COG: begin
                m_tdata = OTW'({o_rh_reg, o_rvy_reg, o_rvx_reg, o_gy_reg, o_gx_reg});
                m_tuser = FRAME_COG;
            end
            BEAT_SENSOR: begin
                m_tdata = OTW'({o_sh_reg, o_svy_reg, o_svx_reg, o_sy_reg, o_sx_reg});
                m_tuser = FRAME_SENSOR;
            end
            default: begin
                m_tdata = '0;
                m_tuser = FRAME_REAR;
            end
        endcase
    end

    assign m_tvalid = ser_valid_reg;
    assign m_tlast  = (beat_reg == BEAT_SENSOR);

    `SFFT_ASSERT_NOW(a_last_is_sensor, m_tvalid && m_tlast, m_tuser == FRAME_SENSOR, "last beat not sensor frame")
    `SFFT_ASSERT_NEXT(a_set_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "result set cut short")
    `SFFT_ASSERT_NOW(a_stall_holds_input, valid_reg[NSTG-1] && ser_valid_reg && !m_tready, !s_tready, "input taken while full")

endmodule
